// File: rtl/core/llog_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llog_pkg: shared types and constants
// Request layout, decision and kind codes, engine states, arctangent table.
// ---------------------------------------------------------------------------
package llog_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned DivSteps    = 32;

  localparam logic [2:0] ADDR_HTOL = 3'd0;
  localparam logic [2:0] ADDR_ALIM = 3'd4;

  localparam logic [14:0] HTOL_RESET = 15'd1280;
  localparam logic [7:0]  ALIM_RESET = 8'd20;

  localparam logic signed [24:0] ANG_POS90 = 25'sd5898240;
  localparam logic signed [24:0] ANG_NEG90 = -25'sd5898240;

  typedef enum logic [2:0] {
    DEC_ACCEPT = 3'd0,
    DEC_ANGLE  = 3'd1,
    DEC_JUMP   = 3'd2,
    DEC_HELD   = 3'd3,
    DEC_KEEP   = 3'd4
  } decision_t;

  typedef enum logic [1:0] {
    KIND_CHECK = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_HOLD  = 2'd2,
    KIND_KEEP  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_LD,
    ST_ANG_RUN,
    ST_ANG_END,
    ST_MUL,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_POST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        lane;
    kind_t       kind;
    logic [15:0] cur_dir_x;
    logic [15:0] cur_dir_y;
    logic [15:0] cur_base_x;
    logic [15:0] cur_base_y;
    logic [15:0] prev_dir_x;
    logic [15:0] prev_dir_y;
    logic [15:0] prev_base_x;
    logic [15:0] prev_base_y;
  } item_t;

  function automatic logic [21:0] atan_deg(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/lane_line_outlier_gate_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lane_line_outlier_gate_core: lane line outlier gate
// Replaces a lane line by the previous frame's line on angle or intercept jump.
// ---------------------------------------------------------------------------
// One request is worked at a time by a single sequencer; a two-entry queue in
// front accepts requests meanwhile. An unchanged line goes straight to the
// result; a plain or held line takes one multiply and a 32-step
// one-bit-per-cycle divider, a checked line first takes two 16-step CORDIC
// angle runs that share one unit, and when the jump check reverts the
// intercept is multiplied and divided again; a zero divisor skips the divider,
// and a stalled result holds the sequencer until it is taken.
// ---------------------------------------------------------------------------
module lane_line_outlier_gate_core #(
  parameter int NUM_LANES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_lane,
  input  logic        in_detected,
  input  logic        in_history_valid,
  input  logic [15:0] in_cur_dir_x,
  input  logic [15:0] in_cur_dir_y,
  input  logic [15:0] in_cur_base_x,
  input  logic [15:0] in_cur_base_y,
  input  logic [15:0] in_prev_dir_x,
  input  logic [15:0] in_prev_dir_y,
  input  logic [15:0] in_prev_base_x,
  input  logic [15:0] in_prev_base_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_dir_x,
  output logic [15:0] out_dir_y,
  output logic [15:0] out_base_x,
  output logic [15:0] out_base_y,
  output logic [15:0] out_top_x,
  output logic [2:0]  out_decision,
  output logic        out_top_x_saturated
);

  logic [14:0]     htol_r;
  logic [7:0]      alim_r;
  logic            wr;
  logic            q_valid;
  logic            q_pop;
  llog_pkg::item_t q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      htol_r <= llog_pkg::HTOL_RESET;
      alim_r <= llog_pkg::ALIM_RESET;
    end else if (wr) begin
      if (paddr[2] == llog_pkg::ADDR_HTOL[2]) begin
        htol_r <= pwdata[14:0];
      end else begin
        alim_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == llog_pkg::ADDR_ALIM[2]) begin
      prdata = {24'd0, alim_r};
    end else begin
      prdata = {17'd0, htol_r};
    end
  end

  llog_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lane          (in_lane),
    .in_detected      (in_detected),
    .in_history_valid (in_history_valid),
    .in_cur_dir_x     (in_cur_dir_x),
    .in_cur_dir_y     (in_cur_dir_y),
    .in_cur_base_x    (in_cur_base_x),
    .in_cur_base_y    (in_cur_base_y),
    .in_prev_dir_x    (in_prev_dir_x),
    .in_prev_dir_y    (in_prev_dir_y),
    .in_prev_base_x   (in_prev_base_x),
    .in_prev_base_y   (in_prev_base_y),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  llog_engine #(
    .NUM_LANES (NUM_LANES)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .htol                (htol_r),
    .alim                (alim_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dir_x           (out_dir_x),
    .out_dir_y           (out_dir_y),
    .out_base_x          (out_base_x),
    .out_base_y          (out_base_y),
    .out_top_x           (out_top_x),
    .out_decision        (out_decision),
    .out_top_x_saturated (out_top_x_saturated)
  );

endmodule

// File: rtl/core/llog_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llog_front: request intake
// Accepts requests, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module llog_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_lane,
  input  logic                 in_detected,
  input  logic                 in_history_valid,
  input  logic [15:0]          in_cur_dir_x,
  input  logic [15:0]          in_cur_dir_y,
  input  logic [15:0]          in_cur_base_x,
  input  logic [15:0]          in_cur_base_y,
  input  logic [15:0]          in_prev_dir_x,
  input  logic [15:0]          in_prev_dir_y,
  input  logic [15:0]          in_prev_base_x,
  input  logic [15:0]          in_prev_base_y,
  output logic                 q_valid,
  output llog_pkg::item_t      q_item,
  input  logic                 q_pop
);

  llog_pkg::item_t q_r [2];
  logic            wptr_r, wptr_nxt;
  logic            rptr_r, rptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  logic            prev_ok;
  llog_pkg::item_t item;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign prev_ok  = (in_prev_dir_x != 16'd0) && (in_prev_dir_y != 16'd0);

  always_comb begin
    item.lane        = in_lane;
    item.cur_dir_x   = in_cur_dir_x;
    item.cur_dir_y   = in_cur_dir_y;
    item.cur_base_x  = in_cur_base_x;
    item.cur_base_y  = in_cur_base_y;
    item.prev_dir_x  = in_prev_dir_x;
    item.prev_dir_y  = in_prev_dir_y;
    item.prev_base_x = in_prev_base_x;
    item.prev_base_y = in_prev_base_y;
    if (in_detected) begin
      item.kind = (in_history_valid && prev_ok) ? llog_pkg::KIND_CHECK : llog_pkg::KIND_PLAIN;
    end else begin
      item.kind = prev_ok ? llog_pkg::KIND_HOLD : llog_pkg::KIND_KEEP;
    end
  end

  assign q_valid = (count_r != 2'd0);
  assign q_item  = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = q_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= item;
    end
  end

endmodule

// File: rtl/core/llog_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llog_engine: line check sequencer
// Runs the angle CORDIC, the intercept multiply and divide, the jump check,
// and holds the result register.
// ---------------------------------------------------------------------------
module llog_engine #(
  parameter int NUM_LANES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  llog_pkg::item_t      q_item,
  output logic                 q_pop,
  input  logic [14:0]          htol,
  input  logic [7:0]           alim,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_dir_x,
  output logic [15:0]          out_dir_y,
  output logic [15:0]          out_base_x,
  output logic [15:0]          out_base_y,
  output logic [15:0]          out_top_x,
  output logic [2:0]           out_decision,
  output logic                 out_top_x_saturated
);

  localparam int LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

  llog_pkg::state_t    state_r, state_nxt;
  llog_pkg::item_t     it_r, it_nxt;
  llog_pkg::decision_t dec_r, dec_nxt;
  logic [LW-1:0]       lane_r, lane_nxt, q_lane;
  logic                sel_prev_r, sel_prev_nxt;
  logic                rechk_r, rechk_nxt;
  logic                phase_r, phase_nxt;
  logic                und_r, und_nxt;
  logic                und1_r, und1_nxt;
  logic signed [27:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [24:0]  cz_r, cz_nxt, a1_r, a1_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic signed [31:0]  prod_r, prod_nxt;
  logic [31:0]         num_r, num_nxt, quo_r, quo_nxt;
  logic [16:0]         den_r, den_nxt;
  logic [16:0]         rem_r, rem_nxt;
  logic signed [15:0]  top_r, top_nxt;
  logic                sat_r, sat_nxt;
  logic signed [15:0]  last_r [NUM_LANES];
  logic                last_we;
  logic                out_valid_r;
  logic [15:0]         o_dx_r, o_dy_r, o_bx_r, o_by_r, o_top_r;
  logic [2:0]          o_dec_r;
  logic                o_sat_r;
  logic                out_load;

  logic signed [15:0]  sdx, sdy, sbx, sby, ax, ay;
  logic signed [16:0]  nx0, ny0;
  logic signed [27:0]  shx, shy;
  logic signed [25:0]  adiff;
  logic [31:0]         un;
  logic [15:0]         ud;
  logic [17:0]         trial;
  logic signed [33:0]  qs, tt;
  logic signed [17:0]  jump;

  assign q_lane = (int'(q_item.lane) >= NUM_LANES) ? LW'(NUM_LANES - 1) : LW'(q_item.lane);

  always_comb begin
    sdx = signed'(sel_prev_r ? it_r.prev_dir_x  : it_r.cur_dir_x);
    sdy = signed'(sel_prev_r ? it_r.prev_dir_y  : it_r.cur_dir_y);
    sbx = signed'(sel_prev_r ? it_r.prev_base_x : it_r.cur_base_x);
    sby = signed'(sel_prev_r ? it_r.prev_base_y : it_r.cur_base_y);
    ax  = signed'(phase_r ? it_r.prev_dir_x : it_r.cur_dir_x);
    ay  = signed'(phase_r ? it_r.prev_dir_y : it_r.cur_dir_y);
    nx0 = ax[15] ? -17'(ax) : 17'(ax);
    ny0 = ax[15] ? -17'(ay) : 17'(ay);
    shx = cx_r >>> cnt_r[3:0];
    shy = cy_r >>> cnt_r[3:0];
    adiff = 26'(a1_r) - 26'(cz_r);
    un  = prod_r[31] ? 32'(-33'(prod_r)) : 32'(prod_r);
    ud  = sdy[15] ? 16'(-17'(sdy)) : 16'(sdy);
    trial = {rem_r, num_r[31]};
    qs  = (prod_r[31] != sdy[15]) ? -34'(quo_r) : 34'(quo_r);
    tt  = 34'(sbx) - qs;
    jump = 18'(last_r[lane_r]) - 18'(top_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llog_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            llog_pkg::KIND_CHECK: state_nxt = llog_pkg::ST_ANG_LD;
            llog_pkg::KIND_KEEP:  state_nxt = llog_pkg::ST_DONE;
            default:              state_nxt = llog_pkg::ST_MUL;
          endcase
        end
      end
      llog_pkg::ST_ANG_LD:  state_nxt = (nx0 == 17'sd0) ? llog_pkg::ST_ANG_END
                                                          : llog_pkg::ST_ANG_RUN;
      llog_pkg::ST_ANG_RUN: begin
        if (cnt_r == 5'(llog_pkg::CordicSteps - 1)) state_nxt = llog_pkg::ST_ANG_END;
      end
      llog_pkg::ST_ANG_END: state_nxt = phase_r ? llog_pkg::ST_MUL : llog_pkg::ST_ANG_LD;
      llog_pkg::ST_MUL:     state_nxt = llog_pkg::ST_DIV_LD;
      llog_pkg::ST_DIV_LD:  state_nxt = (sdy == 16'sd0) ? llog_pkg::ST_POST
                                                         : llog_pkg::ST_DIV_RUN;
      llog_pkg::ST_DIV_RUN: begin
        if (cnt_r == 5'(llog_pkg::DivSteps - 1)) state_nxt = llog_pkg::ST_DIV_END;
      end
      llog_pkg::ST_DIV_END: state_nxt = llog_pkg::ST_POST;
      llog_pkg::ST_POST: begin
        if (it_r.kind == llog_pkg::KIND_CHECK && !rechk_r &&
            ((jump[17] ? -jump : jump) > 18'sd0 + 18'(htol))) begin
          state_nxt = llog_pkg::ST_MUL;
        end else begin
          state_nxt = llog_pkg::ST_DONE;
        end
      end
      llog_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = llog_pkg::ST_IDLE;
      end
      default: state_nxt = llog_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    it_nxt       = it_r;
    dec_nxt      = dec_r;
    lane_nxt     = lane_r;
    sel_prev_nxt = sel_prev_r;
    rechk_nxt    = rechk_r;
    phase_nxt    = phase_r;
    und_nxt      = und_r;
    und1_nxt     = und1_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    a1_nxt       = a1_r;
    cnt_nxt      = cnt_r;
    prod_nxt     = prod_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    top_nxt      = top_r;
    sat_nxt      = sat_r;
    q_pop        = 1'b0;
    last_we      = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      llog_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          it_nxt       = q_item;
          lane_nxt     = q_lane;
          rechk_nxt    = 1'b0;
          phase_nxt    = 1'b0;
          sat_nxt      = 1'b0;
          top_nxt      = last_r[q_lane];
          sel_prev_nxt = (q_item.kind == llog_pkg::KIND_HOLD);
          unique case (q_item.kind)
            llog_pkg::KIND_HOLD: dec_nxt = llog_pkg::DEC_HELD;
            llog_pkg::KIND_KEEP: dec_nxt = llog_pkg::DEC_KEEP;
            default:             dec_nxt = llog_pkg::DEC_ACCEPT;
          endcase
        end
      end
      llog_pkg::ST_ANG_LD: begin
        cnt_nxt = 5'd0;
        und_nxt = 1'b0;
        if (nx0 == 17'sd0) begin
          und_nxt = (ny0 == 17'sd0);
          cz_nxt  = ny0[16] ? llog_pkg::ANG_NEG90 : llog_pkg::ANG_POS90;
        end else begin
          cx_nxt = 28'(nx0) <<< 8;
          cy_nxt = 28'(ny0) <<< 8;
          cz_nxt = 25'sd0;
        end
      end
      llog_pkg::ST_ANG_RUN: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cy_r > 28'sd0) begin
          cx_nxt = cx_r + shy;
          cy_nxt = cy_r - shx;
          cz_nxt = cz_r + 25'(llog_pkg::atan_deg(cnt_r[3:0]));
        end else begin
          cx_nxt = cx_r - shy;
          cy_nxt = cy_r + shx;
          cz_nxt = cz_r - 25'(llog_pkg::atan_deg(cnt_r[3:0]));
        end
      end
      llog_pkg::ST_ANG_END: begin
        if (!phase_r) begin
          a1_nxt    = cz_r;
          und1_nxt  = und_r;
          phase_nxt = 1'b1;
        end else if (!und1_r &&
                     ((adiff[25] ? -adiff : adiff) > 26'sd0 + {2'b00, alim, 16'h0000})) begin
          sel_prev_nxt = 1'b1;
          dec_nxt      = llog_pkg::DEC_ANGLE;
        end
      end
      llog_pkg::ST_MUL: begin
        prod_nxt = sby * sdx;
      end
      llog_pkg::ST_DIV_LD: begin
        cnt_nxt = 5'd0;
        rem_nxt = 17'd0;
        quo_nxt = 32'd0;
        num_nxt = {un[30:0], 1'b0} + 32'(ud);
        den_nxt = {ud, 1'b0};
        if (sdy == 16'sd0) begin
          sat_nxt = 1'b1;
          if (prod_r > 32'sd0)      top_nxt = -16'sd32768;
          else if (prod_r < 32'sd0) top_nxt = 16'sd32767;
          else                      top_nxt = sbx;
        end
      end
      llog_pkg::ST_DIV_RUN: begin
        cnt_nxt = cnt_r + 5'd1;
        num_nxt = {num_r[30:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = 17'(trial - {1'b0, den_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[16:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
      llog_pkg::ST_DIV_END: begin
        if (tt > 34'sd32767) begin
          top_nxt = 16'sd32767;
          sat_nxt = 1'b1;
        end else if (tt < -34'sd32768) begin
          top_nxt = -16'sd32768;
          sat_nxt = 1'b1;
        end else begin
          top_nxt = tt[15:0];
          sat_nxt = 1'b0;
        end
      end
      llog_pkg::ST_POST: begin
        if (state_nxt == llog_pkg::ST_MUL) begin
          sel_prev_nxt = 1'b1;
          rechk_nxt    = 1'b1;
          dec_nxt      = llog_pkg::DEC_JUMP;
        end else begin
          last_we = 1'b1;
        end
      end
      llog_pkg::ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llog_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        last_r[i] <= 16'sd0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (last_we) begin
        last_r[lane_r] <= top_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    it_r       <= it_nxt;
    dec_r      <= dec_nxt;
    lane_r     <= lane_nxt;
    sel_prev_r <= sel_prev_nxt;
    rechk_r    <= rechk_nxt;
    phase_r    <= phase_nxt;
    und_r      <= und_nxt;
    und1_r     <= und1_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    a1_r       <= a1_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    top_r      <= top_nxt;
    sat_r      <= sat_nxt;
    if (out_load) begin
      o_dx_r  <= sdx;
      o_dy_r  <= sdy;
      o_bx_r  <= sbx;
      o_by_r  <= sby;
      o_top_r <= top_r;
      o_dec_r <= dec_r;
      o_sat_r <= sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dir_x           = o_dx_r;
  assign out_dir_y           = o_dy_r;
  assign out_base_x          = o_bx_r;
  assign out_base_y          = o_by_r;
  assign out_top_x           = o_top_r;
  assign out_decision        = o_dec_r;
  assign out_top_x_saturated = o_sat_r;

  a_keep_unsat: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && dec_r == llog_pkg::DEC_KEEP |-> !sat_r)
    else $error("unchanged line reported saturated");

  a_angle_checked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == llog_pkg::ST_MUL && dec_r == llog_pkg::DEC_ANGLE |->
      it_r.kind == llog_pkg::KIND_CHECK)
    else $error("angle revert on unchecked request");

  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == llog_pkg::ST_DIV_RUN |=>
      state_r == llog_pkg::ST_DIV_RUN || state_r == llog_pkg::ST_DIV_END)
    else $error("divider left early");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && state_r == llog_pkg::ST_IDLE)
    else $error("pop outside idle");

endmodule
